>>> design/gdbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdbd_pkg
// Shared types, constants and calendar tables for the Gregorian day
// difference pipeline.
// ----------------------------------------------------------------------------
package gdbd_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 24;

    // year / 100 by reciprocal: exact for every 14-bit year
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 27;
    localparam int CENT_W      = PROD_W - RECIP_SHIFT;

    // day-of-year offset width and day number pieces
    localparam int DOY_W = 9;
    localparam int ADJ_W = 13;

    localparam int YEAR_MIN = 1;
    localparam int YEAR_MAX = 9999;
    localparam int MONTH_MAX = 12;
    localparam int CENTURY   = 100;
    localparam int YEAR_DAYS = 365;

    localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
    localparam logic [MONTH_W-1:0] APRIL     = 4'd4;
    localparam logic [MONTH_W-1:0] JUNE      = 4'd6;
    localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
    localparam logic [MONTH_W-1:0] NOVEMBER  = 4'd11;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ORDER   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    // per-stage load enables, stage a is the input register
    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
        logic ld_d;
        logic ld_e;
        logic ld_f;
    } gdbd_en_t;

    // days before the first of a month, month given as 1..12
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        begin
            case (m)
                4'd1:    r = 9'd0;
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // length of a month in days
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        begin
            if (m == FEBRUARY) begin
                r = leap ? 5'd29 : 5'd28;
            end else if (m == APRIL || m == JUNE || m == SEPTEMBER || m == NOVEMBER) begin
                r = 5'd30;
            end else begin
                r = 5'd31;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/gdbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdbd_ctrl
// Valid bits and load enables for the six-stage pipeline. A stage loads
// when it is empty or its contents move on, so bubbles close up under stall.
// ----------------------------------------------------------------------------
module gdbd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output gdbd_pkg::gdbd_en_t     en
);
    import gdbd_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] ld;
    logic [NSTG-1:0] feed;

    // ready ripples back from the output register
    always_comb begin
        ld[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            ld[i] = !valid_reg[i] || ld[i+1];
        end
    end

    assign feed = {valid_reg[NSTG-2:0], s_tvalid};

    always_comb begin
        for (int i = 0; i < NSTG; i++) begin
            valid_next[i] = ld[i] ? feed[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ld[0];
    assign m_tvalid = valid_reg[NSTG-1];
    assign en = '{ld_a: ld[0], ld_b: ld[1], ld_c: ld[2],
                  ld_d: ld[3], ld_e: ld[4], ld_f: ld[5]};

endmodule
`default_nettype wire

>>> design/gdbd_date.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdbd_date
// Date check and absolute day number (0001-01-01 is day 1), stages a to e.
// ----------------------------------------------------------------------------
module gdbd_date (
    input  wire logic                         aclk,
    input  wire gdbd_pkg::gdbd_en_t           en,
    input  wire logic [gdbd_pkg::YEAR_W-1:0]  year,
    input  wire logic [gdbd_pkg::MONTH_W-1:0] month,
    input  wire logic [gdbd_pkg::DAY_W-1:0]   day,
    output logic [gdbd_pkg::COUNT_W-1:0]      day_num,
    output logic                              date_ok
);
    import gdbd_pkg::*;

    // stage a: input word
    logic [YEAR_W-1:0]  y_a_reg;
    logic [MONTH_W-1:0] m_a_reg;
    logic [DAY_W-1:0]   d_a_reg;

    // stage b: year / 100 products
    logic [YEAR_W-1:0]  y_b_reg;
    logic [YEAR_W-1:0]  p_b_reg;
    logic [MONTH_W-1:0] m_b_reg;
    logic [DAY_W-1:0]   d_b_reg;
    logic [PROD_W-1:0]  prod_y_b_reg;
    logic [PROD_W-1:0]  prod_p_b_reg;
    logic [YEAR_W-1:0]  p_b_next;

    // stage c: leap flag, centuries, year and month range
    logic [YEAR_W-1:0]  p_c_reg;
    logic [CENT_W-1:0]  qp_c_reg;
    logic [MONTH_W-1:0] m_c_reg;
    logic [DAY_W-1:0]   d_c_reg;
    logic               leap_c_reg;
    logic               ymok_c_reg;
    logic [CENT_W-1:0]  qy_c_next;
    logic               leap_c_next;
    logic               ymok_c_next;

    // stage d: day number in two parts
    logic [COUNT_W-1:0] base_d_reg;
    logic [ADJ_W-1:0]   adj_d_reg;
    logic               ok_d_reg;
    logic [COUNT_W-1:0] base_d_next;
    logic [ADJ_W-1:0]   adj_d_next;
    logic               ok_d_next;

    // stage e: day number
    logic [COUNT_W-1:0] n_e_reg;
    logic               ok_e_reg;

    always_ff @(posedge aclk) begin
        if (en.ld_a) begin
            y_a_reg <= year;
            m_a_reg <= month;
            d_a_reg <= day;
        end
    end

    // multiply by the reciprocal of 100
    assign p_b_next = y_a_reg - YEAR_W'(1);

    always_ff @(posedge aclk) begin
        if (en.ld_b) begin
            y_b_reg      <= y_a_reg;
            p_b_reg      <= p_b_next;
            m_b_reg      <= m_a_reg;
            d_b_reg      <= d_a_reg;
            prod_y_b_reg <= PROD_W'(y_a_reg) * PROD_W'(RECIP);
            prod_p_b_reg <= PROD_W'(p_b_next) * PROD_W'(RECIP);
        end
    end

    // leap year: divisible by 4, and not a century unless divisible by 400
    always_comb begin
        qy_c_next   = prod_y_b_reg[PROD_W-1:RECIP_SHIFT];
        leap_c_next = (y_b_reg[1:0] == 2'b00) &&
                      (({1'b0, y_b_reg} != (YEAR_W+1)'(qy_c_next) * (YEAR_W+1)'(CENTURY)) ||
                       (qy_c_next[1:0] == 2'b00));
        ymok_c_next = (y_b_reg >= YEAR_W'(YEAR_MIN)) && (y_b_reg <= YEAR_W'(YEAR_MAX)) &&
                      (m_b_reg != '0) && (m_b_reg <= MONTH_W'(MONTH_MAX));
    end

    always_ff @(posedge aclk) begin
        if (en.ld_c) begin
            p_c_reg    <= p_b_reg;
            qp_c_reg   <= prod_p_b_reg[PROD_W-1:RECIP_SHIFT];
            m_c_reg    <= m_b_reg;
            d_c_reg    <= d_b_reg;
            leap_c_reg <= leap_c_next;
            ymok_c_reg <= ymok_c_next;
        end
    end

    // p*365 on one side, leap days, month offset and day on the other
    always_comb begin
        base_d_next = COUNT_W'(p_c_reg) * COUNT_W'(YEAR_DAYS);
        adj_d_next  = ADJ_W'(p_c_reg >> 2) - ADJ_W'(qp_c_reg) + ADJ_W'(qp_c_reg >> 2)
                    + ADJ_W'(days_before(m_c_reg))
                    + ADJ_W'(leap_c_reg && (m_c_reg > FEBRUARY))
                    + ADJ_W'(d_c_reg);
        ok_d_next   = ymok_c_reg && (d_c_reg != '0) &&
                      (d_c_reg <= month_len(m_c_reg, leap_c_reg));
    end

    always_ff @(posedge aclk) begin
        if (en.ld_d) begin
            base_d_reg <= base_d_next;
            adj_d_reg  <= adj_d_next;
            ok_d_reg   <= ok_d_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld_e) begin
            n_e_reg  <= base_d_reg + COUNT_W'(adj_d_reg);
            ok_e_reg <= ok_d_reg;
        end
    end

    assign day_num = n_e_reg;
    assign date_ok = ok_e_reg;

endmodule
`default_nettype wire

>>> design/gregorian_days_between_dates.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath: stage a is the input register, stages b to e follow, and stage f drives m_tdata.
// Throughput: one word per cycle while m_tready is high; six register stages, each with its own valid bit.
// Stalls: an empty stage still loads, so bubbles close up while m_tready is low.
// Reset: aresetn (synchronous, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
// gregorian_days_between_dates
// Days from the first Gregorian date to the second, with date checks and
// an order check. Both dates go through their own day number pipeline.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [13:0] first_year, [17:14] first_month, [22:18] first_day,
    // [36:23] second_year, [40:37] second_month, [45:41] second_day,
    // [46] include_first_day, [47] zero
    input  wire logic [gdbd_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [21:0] day_count, [23:22] status
    output logic [gdbd_pkg::OUT_W-1:0]       m_tdata
);
    import gdbd_pkg::*;

    gdbd_en_t           en;
    logic [COUNT_W-1:0] n1;
    logic [COUNT_W-1:0] n2;
    logic               ok1;
    logic               ok2;

    // include-first-day flag rides alongside stages a to e
    logic [4:0]         inc_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [COUNT_W-1:0] count_next;
    logic [STAT_W-1:0]  status_next;

    gdbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .en       (en)
    );

    gdbd_date u_first (
        .aclk    (aclk),
        .en      (en),
        .year    (s_tdata[13:0]),
        .month   (s_tdata[17:14]),
        .day     (s_tdata[22:18]),
        .day_num (n1),
        .date_ok (ok1)
    );

    gdbd_date u_second (
        .aclk    (aclk),
        .en      (en),
        .year    (s_tdata[36:23]),
        .month   (s_tdata[40:37]),
        .day     (s_tdata[45:41]),
        .day_num (n2),
        .date_ok (ok2)
    );

    always_ff @(posedge aclk) begin
        if (en.ld_a) inc_reg[0] <= s_tdata[46];
        if (en.ld_b) inc_reg[1] <= inc_reg[0];
        if (en.ld_c) inc_reg[2] <= inc_reg[1];
        if (en.ld_d) inc_reg[3] <= inc_reg[2];
        if (en.ld_e) inc_reg[4] <= inc_reg[3];
    end

    // invalid date wins over order; count is zero unless ok
    always_comb begin
        count_next  = '0;
        status_next = ST_OK;
        if (!(ok1 && ok2)) begin
            status_next = ST_INVALID;
        end else if (n1 >= n2) begin
            status_next = ST_ORDER;
        end else begin
            count_next = n2 - n1 + COUNT_W'(inc_reg[4]);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en.ld_f) begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign m_tdata = {status_reg, count_reg};

endmodule
`default_nettype wire
